// ===== hw/rtl/tccd_pkg.sv =====
package tccd_pkg;

   localparam int MaxCells = 3;
   localparam int IdxWidth = $clog2(MaxCells);

   typedef enum logic [1:0] {
      KIND_CODE,
      KIND_DEGREE,
      KIND_DIAMETER,
      KIND_PLUSMINUS
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] code;
   } cell_type;

   // Cells raised by one input word, emitted from index 0 up
   typedef struct packed {
      cell_type [MaxCells-1:0] cells;
      logic [IdxWidth-1:0]     count;
      logic                    overline;
      logic                    underline;
   } burst_type;

endpackage

// ===== hw/rtl/text_control_code_decoder_core.sv =====
// Path: an accepted byte is held in the input register, then decoded into the cell
// queue, whose head cell drives rsp.
// Throughput: one byte per cycle while bytes give at most one cell and rsp is ready;
// a byte with more cells holds the queue, and so req, until its last cell is taken.
// Reset: synchronous, active high; clears the input register, the escape state, the
// overline and underline flags and the cell queue.
module text_control_code_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // text_byte[7:0]
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // char_code[7:0]
   output logic [3:0] rsp_tuser,   // cell_kind[1:0], overline_on, underline_on
   output logic       rsp_tlast    // last_of_run
);
   import tccd_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   logic      can_load;
   logic      advance;
   burst_type burst;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // hold the word while the queue is still draining
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   tccd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .text_byte     (in_byte_ff),
      .end_of_string (in_end_ff),
      .burst         (burst)
   );

   tccd_cell_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load_req   (in_valid_ff),
      .burst_in   (burst),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !can_load) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff)))
      else $error("input word lost while queue busy");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stalled with empty register");

endmodule

// ===== hw/rtl/tccd_decode.sv =====
module tccd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          text_byte,
   input  logic                end_of_string,
   output tccd_pkg::burst_type burst
);
   import tccd_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ONE,
      MODE_TWO,
      MODE_DIGITS
   } mode_type;

   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChLowerD  = 8'h64;
   localparam logic [7:0] ChLowerC  = 8'h63;
   localparam logic [7:0] ChLowerP  = 8'h70;
   localparam logic [7:0] ChLowerO  = 8'h6f;
   localparam logic [7:0] ChLowerU  = 8'h75;
   localparam logic [9:0] CodeLimit = 10'd255;

   mode_type   mode_ff, mode_in;
   logic [9:0] value_ff, value_in;
   logic [1:0] count_ff, count_in;
   logic       overline_ff, overline_in;
   logic       underline_ff, underline_in;

   logic [7:0]  lower;
   logic        is_pct;
   logic        is_digit;
   logic [3:0]  digit;
   logic [13:0] acc_wide;
   logic [9:0]  acc;
   logic [1:0]  count_step;

   function automatic cell_type code_cell(input logic [7:0] code);
      cell_type c;
      c.kind = KIND_CODE;
      c.code = code;
      return c;
   endfunction

   function automatic cell_type symbol_cell(input kind_type kind);
      cell_type c;
      c.kind = kind;
      c.code = 8'd0;
      return c;
   endfunction

   // Codes above the byte range collapse to zero
   function automatic logic [7:0] digit_code(input logic [9:0] v);
      return (v <= CodeLimit) ? v[7:0] : 8'd0;
   endfunction

   always_comb begin
      lower      = (text_byte >= 8'h41 && text_byte <= 8'h5a) ? text_byte + 8'h20 : text_byte;
      is_pct     = text_byte == ChPercent;
      is_digit   = text_byte >= 8'h30 && text_byte <= 8'h39;
      digit      = text_byte[3:0];
      acc_wide   = 14'(value_ff) * 14'd10 + 14'(digit);
      acc        = acc_wide[9:0];
      count_step = count_ff + 2'd1;

      mode_in      = mode_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      overline_in  = overline_ff;
      underline_in = underline_ff;

      burst           = '0;
      burst.overline  = overline_ff;
      burst.underline = underline_ff;

      unique case (mode_ff)
         MODE_IDLE: begin
            if (is_pct && !end_of_string) begin
               mode_in = MODE_ONE;
            end else begin
               burst.cells[0] = code_cell(text_byte);
               burst.count    = 2'd1;
            end
         end
         MODE_ONE: begin
            if (is_pct && !end_of_string) begin
               mode_in = MODE_TWO;
            end else begin
               // a second percent on the last word stays literal as well
               burst.cells[0] = code_cell(ChPercent);
               burst.cells[1] = code_cell(text_byte);
               burst.count    = 2'd2;
               mode_in        = MODE_IDLE;
            end
         end
         MODE_TWO: begin
            mode_in = MODE_IDLE;
            unique case (lower)
               ChLowerD: begin
                  burst.cells[0] = symbol_cell(KIND_DEGREE);
                  burst.count    = 2'd1;
               end
               ChLowerC: begin
                  burst.cells[0] = symbol_cell(KIND_DIAMETER);
                  burst.count    = 2'd1;
               end
               ChLowerP: begin
                  burst.cells[0] = symbol_cell(KIND_PLUSMINUS);
                  burst.count    = 2'd1;
               end
               ChPercent: begin
                  burst.cells[0] = code_cell(ChPercent);
                  burst.count    = 2'd1;
               end
               ChLowerO: overline_in  = !overline_ff;
               ChLowerU: underline_in = !underline_ff;
               default: begin
                  if (is_digit) begin
                     if (end_of_string) begin
                        burst.cells[0] = code_cell({4'd0, digit});
                        burst.count    = 2'd1;
                     end else begin
                        value_in = {6'd0, digit};
                        count_in = 2'd1;
                        mode_in  = MODE_DIGITS;
                     end
                  end else begin
                     burst.cells[0] = code_cell(ChPercent);
                     burst.cells[1] = code_cell(ChPercent);
                     burst.cells[2] = code_cell(text_byte);
                     burst.count    = 2'd3;
                  end
               end
            endcase
         end
         MODE_DIGITS: begin
            if (is_digit) begin
               if (count_step == 2'd3 || count_step == 2'd0 || end_of_string) begin
                  burst.cells[0] = code_cell(digit_code(acc));
                  burst.count    = 2'd1;
                  value_in       = 10'd0;
                  count_in       = 2'd0;
                  mode_in        = MODE_IDLE;
               end else begin
                  value_in = acc;
                  count_in = count_step;
               end
            end else begin
               // close the run, then treat this word as if idle
               burst.cells[0] = code_cell(digit_code(value_ff));
               value_in       = 10'd0;
               count_in       = 2'd0;
               if (is_pct && !end_of_string) begin
                  burst.count = 2'd1;
                  mode_in     = MODE_ONE;
               end else begin
                  burst.cells[1] = code_cell(text_byte);
                  burst.count    = 2'd2;
                  mode_in        = MODE_IDLE;
               end
            end
         end
         default: mode_in = MODE_IDLE;
      endcase

      if (end_of_string) begin
         mode_in      = MODE_IDLE;
         value_in     = 10'd0;
         count_in     = 2'd0;
         overline_in  = 1'b0;
         underline_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         value_ff     <= 10'd0;
         count_ff     <= 2'd0;
         overline_ff  <= 1'b0;
         underline_ff <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         value_ff     <= value_in;
         count_ff     <= count_in;
         overline_ff  <= overline_in;
         underline_ff <= underline_in;
      end
   end

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DIGITS |-> (count_ff == 2'd1 || count_ff == 2'd2))
      else $error("digit run with bad count");

   a_digit_value: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DIGITS |-> value_ff <= 10'd99)
      else $error("pending digit value out of range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && end_of_string) |=>
         (mode_ff == MODE_IDLE && !overline_ff && !underline_ff && count_ff == 2'd0))
      else $error("state not cleared after end of string");

endmodule

// ===== hw/rtl/tccd_cell_queue.sv =====
module tccd_cell_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_req,
   input  tccd_pkg::burst_type burst_in,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // char_code[7:0]
   output logic [3:0]          rsp_tuser,  // cell_kind[1:0], overline_on, underline_on
   output logic                rsp_tlast
);
   import tccd_pkg::*;

   burst_type           burst_ff;
   logic [IdxWidth-1:0] count_ff;
   logic [IdxWidth-1:0] idx_ff;

   cell_type head_cell;
   logic     take;
   logic     at_last;
   logic     last_take;
   logic     load;

   always_comb begin
      head_cell  = burst_ff.cells[idx_ff];
      rsp_tvalid = count_ff != '0;
      at_last    = idx_ff == count_ff - IdxWidth'(1);
      take       = rsp_tvalid && rsp_tready;
      last_take  = take && at_last;
      can_load   = !rsp_tvalid || last_take;
      load       = load_req && can_load;
      rsp_tdata  = head_cell.code;
      rsp_tuser  = {burst_ff.underline, burst_ff.overline, head_cell.kind};
      rsp_tlast  = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= burst_in.count;
         idx_ff   <= '0;
      end else if (last_take) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + IdxWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff < count_ff)
      else $error("cell index past end of burst");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (last_take && !load_req) |=> !rsp_tvalid)
      else $error("queue not empty after final cell");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import tccd_pkg::*;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_ONE,
      SCAN_TWO,
      SCAN_DIGITS
   } scan_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] code;
      logic       overline;
      logic       underline;
      logic       last;
   } glyph_cell_type;

   typedef struct {
      logic [7:0] text;
      logic       eos;
      logic       typed;
      kind_type   kind;
      logic [7:0] code;
   } script_row_type;

   localparam logic [7:0] Pct       = 8'h25;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;
   localparam logic [7:0] CodeLimit = 8'hff;
   localparam int ScriptLen = 42;
   localparam int PhaseWords = 104;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // char_code[7:0]
   logic [3:0] rsp_tuser;   // cell_kind[1:0], overline_on, underline_on
   logic       rsp_tlast;   // last_of_run

   int sender_idle = 0;
   int receiver_stall = 0;
   int mismatches = 0;

   // decoder shadow state
   scan_type   scan = SCAN_IDLE;
   logic [9:0] digit_acc = '0;
   logic [1:0] digit_cnt = '0;
   logic       overline_flag = 1'b0;
   logic       underline_flag = 1'b0;

   glyph_cell_type fresh_cells [$];
   glyph_cell_type pending_cells [$];

   logic [7:0] code_letters [11] = '{"d", "c", "p", "o", "u", "D", "C", "P", "O", "U", Pct};

   // text, end of string, typed, kind, code
   script_row_type script [ScriptLen] = '{
      '{8'h00, 1'b0, 1'b1, KIND_CODE, 8'h00},
      '{8'hff, 1'b1, 1'b1, KIND_CODE, 8'hff},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"d", 1'b0, 1'b1, KIND_DEGREE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"C", 1'b0, 1'b1, KIND_DIAMETER, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"p", 1'b1, 1'b1, KIND_PLUSMINUS, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b1, KIND_CODE, Pct},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"2", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"5", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"6", 1'b0, 1'b1, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"Q", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b1, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"u", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"A", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"7", 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{8'he4, 1'b1, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"4", 1'b1, 1'b1, KIND_CODE, 8'h04},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b0, 1'b0, KIND_CODE, 8'h00},
      '{"o", 1'b1, 1'b0, KIND_CODE, 8'h00},
      '{Pct, 1'b1, 1'b1, KIND_CODE, Pct}
   };

   text_control_code_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void log_mismatch(input string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
   endfunction

   function automatic void add_cell(input kind_type kind, input logic [7:0] code);
      fresh_cells = {fresh_cells,
                     glyph_cell_type'{kind, code, overline_flag, underline_flag, 1'b0}};
   endfunction

   function automatic void plain_byte(input logic [7:0] b, input logic eos);
      if (b == Pct && !eos) begin
         scan = SCAN_ONE;
      end else begin
         scan = SCAN_IDLE;
         add_cell(KIND_CODE, b);
      end
   endfunction

   function automatic void flush_digits();
      add_cell(KIND_CODE, (digit_acc <= CodeLimit) ? digit_acc[7:0] : 8'h00);
      digit_acc = '0;
      digit_cnt = '0;
      scan = SCAN_IDLE;
   endfunction

   // Work out the cells one text byte raises, leaving them in fresh_cells
   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic [7:0] lc;
      logic       is_digit;
      lc = (b >= "A" && b <= "Z") ? 8'(b + 8'h20) : b;
      is_digit = (b >= ChZero && b <= ChNine);
      fresh_cells.delete();
      case (scan)
         SCAN_ONE: begin
            if (b == Pct) begin
               if (eos) begin
                  add_cell(KIND_CODE, Pct);
                  add_cell(KIND_CODE, Pct);
                  scan = SCAN_IDLE;
               end else begin
                  scan = SCAN_TWO;
               end
            end else begin
               add_cell(KIND_CODE, Pct);
               plain_byte(b, eos);
            end
         end
         SCAN_TWO: begin
            scan = SCAN_IDLE;
            if (lc == "d") add_cell(KIND_DEGREE, 8'h00);
            else if (lc == "c") add_cell(KIND_DIAMETER, 8'h00);
            else if (lc == "p") add_cell(KIND_PLUSMINUS, 8'h00);
            else if (lc == Pct) add_cell(KIND_CODE, Pct);
            else if (lc == "o") overline_flag = !overline_flag;
            else if (lc == "u") underline_flag = !underline_flag;
            else if (is_digit) begin
               digit_acc = 10'(b - ChZero);
               digit_cnt = 2'd1;
               if (eos) flush_digits();
               else scan = SCAN_DIGITS;
            end else begin
               // unknown code byte: both percents go out literally, then the byte
               add_cell(KIND_CODE, Pct);
               add_cell(KIND_CODE, Pct);
               add_cell(KIND_CODE, b);
            end
         end
         SCAN_DIGITS: begin
            if (is_digit) begin
               digit_acc = 10'(digit_acc * 10 + (b - ChZero));
               digit_cnt = digit_cnt + 2'd1;
               if (digit_cnt == 2'd3 || digit_cnt == 2'd0 || eos) flush_digits();
            end else begin
               flush_digits();
               plain_byte(b, eos);
            end
         end
         default: plain_byte(b, eos);
      endcase
      if (fresh_cells.size() > 0) fresh_cells[fresh_cells.size()-1].last = 1'b1;
      if (eos) begin
         scan = SCAN_IDLE;
         digit_acc = '0;
         digit_cnt = '0;
         overline_flag = 1'b0;
         underline_flag = 1'b0;
      end
   endfunction

   // Offer one word at the falling edge and hold it until taken
   task automatic send_word(input logic [7:0] b, input logic eos, input logic typed,
                            input kind_type kind, input logic [7:0] code);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, eos);
      if (typed)
         pending_cells = {pending_cells, glyph_cell_type'{kind, code, 1'b0, 1'b0, 1'b1}};
      else pending_cells = {pending_cells, fresh_cells};
      @(negedge clock);
   endtask

   // Build one string of random escapes, percents, digits and bytes, and send it
   task automatic send_string(output int n);
      logic [7:0] text [$];
      int want;
      int pick;
      want = $urandom_range(1, 10);
      while (text.size() < want) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            text = {text, Pct, Pct};
            pick = $urandom_range(99);
            if (pick < 45) text = {text, code_letters[$urandom_range(10)]};
            else if (pick < 75)
               repeat ($urandom_range(1, 3)) text = {text, 8'(ChZero + $urandom_range(9))};
            else if (pick < 92) text = {text, 8'($urandom_range(255))};
            // else leave the pair bare
         end else if (pick < 50) begin
            text = {text, Pct};
         end else if (pick < 60) begin
            text = {text, 8'(ChZero + $urandom_range(9))};
         end else begin
            text = {text, 8'($urandom_range(255))};
         end
      end
      foreach (text[k]) send_word(text[k], k == text.size() - 1, 1'b0, KIND_CODE, 8'h00);
      n = text.size();
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= receiver_stall);

   always @(posedge clock) begin
      glyph_cell_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            log_mismatch($sformatf("cell with none expected: code %02h user %h last %b",
                                   rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = pending_cells.pop_front();
            if (rsp_tdata !== want.code || rsp_tuser[1:0] !== want.kind
                || rsp_tuser[2] !== want.overline || rsp_tuser[3] !== want.underline
                || rsp_tlast !== want.last)
               log_mismatch($sformatf(
                  "exp kind %0d code %02h ovl %b unl %b last %b, got %0d %02h %b %b %b",
                  want.kind, want.code, want.overline, want.underline, want.last,
                  rsp_tuser[1:0], rsp_tdata, rsp_tuser[2], rsp_tuser[3], rsp_tlast));
         end
      end
   end

   initial begin
      int idle_plan [4];
      int stall_plan [4];
      int sent;
      int n;
      int waited;
      idle_plan = '{0, 67, 0, 9};
      stall_plan = '{0, 0, 67, 9};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (script[r])
         send_word(script[r].text, script[r].eos, script[r].typed, script[r].kind,
                   script[r].code);
      for (int p = 0; p < 4; p++) begin
         sender_idle = idle_plan[p];
         receiver_stall = stall_plan[p];
         sent = 0;
         while (sent < PhaseWords) begin
            send_string(n);
            sent += n;
         end
      end
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_cells.size() > 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      // allow stray cells to show up
      repeat (8) @(posedge clock);
      if (pending_cells.size() > 0)
         log_mismatch($sformatf("%0d cells never arrived", pending_cells.size()));
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tccd_pkg.sv
hw/rtl/tccd_decode.sv
hw/rtl/tccd_cell_queue.sv
hw/rtl/text_control_code_decoder_core.sv
tb/tb_top.sv
